### hdl/button_chord_autorepeat_decoder_defines.svh
`ifndef BUTTON_CHORD_AUTOREPEAT_DECODER_DEFINES_SVH
`define BUTTON_CHORD_AUTOREPEAT_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define BCAD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define BCAD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/bcad_pkg.sv
package bcad_pkg;

    localparam int LEVELS_W = 4;
    localparam int KEY_W    = 4;
    localparam int TICKS_W  = 16;
    localparam int CFG_INDEX_W = 2;

    typedef logic [LEVELS_W-1:0]    levels_t;
    typedef logic [KEY_W-1:0]       key_t;
    typedef logic [TICKS_W-1:0]     ticks_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_HOLD_TICKS   = 2'd0;
    localparam cfg_index_t CFG_REPEAT_TICKS = 2'd1;

    localparam ticks_t HOLD_TICKS_RESET   = 16'd50;
    localparam ticks_t REPEAT_TICKS_RESET = 16'd10;

    localparam key_t KEY_NONE  = 4'd0;
    localparam key_t KEY_ALT   = 4'd1;
    localparam key_t KEY_COLOR = 4'd2;
    localparam key_t KEY_SIZE  = 4'd3;
    localparam key_t KEY_RIGHT = 4'd4;
    localparam key_t KEY_LEFT  = 4'd5;
    localparam key_t KEY_DOWN  = 4'd6;
    localparam key_t KEY_UP    = 4'd7;
    localparam key_t KEY_CLEAR = 4'd8;

    // Button masks: bit0 A, bit1 B, bit2 X, bit3 Y
    localparam levels_t MASK_ALT   = 4'b0001;
    localparam levels_t MASK_COLOR = 4'b0010;
    localparam levels_t MASK_SIZE  = 4'b0011;
    localparam levels_t MASK_RIGHT = 4'b0100;
    localparam levels_t MASK_LEFT  = 4'b0101;
    localparam levels_t MASK_DOWN  = 4'b1000;
    localparam levels_t MASK_UP    = 4'b1001;
    localparam levels_t MASK_CLEAR = 4'b0111;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_PRESSED = 2'd1,
        MODE_HELD    = 2'd2,
        MODE_WAITING = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t   mode;
        levels_t prev_levels;
        ticks_t  countdown;
        key_t    latched_key;
    } state_t;

    function automatic key_t key_of_mask(levels_t mask);
        key_t key;
        unique case (mask)
            MASK_ALT:   key = KEY_ALT;
            MASK_COLOR: key = KEY_COLOR;
            MASK_SIZE:  key = KEY_SIZE;
            MASK_RIGHT: key = KEY_RIGHT;
            MASK_LEFT:  key = KEY_LEFT;
            MASK_DOWN:  key = KEY_DOWN;
            MASK_UP:    key = KEY_UP;
            MASK_CLEAR: key = KEY_CLEAR;
            default:    key = KEY_NONE;
        endcase
        return key;
    endfunction

    function automatic logic key_is_chord(key_t key);
        return (key == KEY_SIZE) || (key == KEY_LEFT) || (key == KEY_UP) ||
               (key == KEY_CLEAR);
    endfunction

endpackage

### hdl/bcad_if.sv
interface bcad_in_if;
    import bcad_pkg::*;

    logic    valid;
    logic    ready;
    levels_t pressed_levels;

    modport source (output valid, output pressed_levels, input ready);
    modport sink (input valid, input pressed_levels, output ready);
endinterface

interface bcad_out_if;
    import bcad_pkg::*;

    logic valid;
    logic ready;
    key_t event_key;

    modport source (output valid, output event_key, input ready);
    modport sink (input valid, input event_key, output ready);
endinterface

### hdl/button_chord_autorepeat_decoder.sv
// Turns one sample of four debounced button levels (A, B, X, Y) per request into
// exactly one key event per response: single presses, chords, a held key after
// hold_ticks samples and repeats every repeat_ticks samples (Alt never repeats).
// A new request is taken every clock cycle unless back-pressure stalls the input;
// each response passes through the input register, then the result register, and
// the chord state machine and its counter update as each request advances.
// Back-pressure on the response side stalls the input side only once both
// registers are full. Write hold_ticks and repeat_ticks only while no request is
// in flight; new values apply at the next counter reload.
`include "button_chord_autorepeat_decoder_defines.svh"

module button_chord_autorepeat_decoder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  bcad_pkg::cfg_index_t cfg_index,
    input  bcad_pkg::ticks_t     cfg_data,
    bcad_in_if.sink              req,
    bcad_out_if.source           rsp
);
    import bcad_pkg::*;

    logic    s1_valid_reg;
    levels_t s1_levels_reg;
    logic    out_valid_reg;
    key_t    out_key_reg;
    state_t  state_reg;
    state_t  state_next;
    key_t    event_next;
    ticks_t  hold_ticks_reg;
    ticks_t  repeat_ticks_reg;
    logic    advance;
    logic    req_take;
    logic    idle_step;
    logic    alt_hold_step;
    logic    wait_step;
    logic    s1_stalled;
    logic    out_none;
    logic    step_none;

    assign advance   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;
    assign req_take  = req.valid && req.ready;

    assign rsp.valid     = out_valid_reg;
    assign rsp.event_key = out_key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ticks_reg   <= HOLD_TICKS_RESET;
            repeat_ticks_reg <= REPEAT_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HOLD_TICKS:   hold_ticks_reg   <= cfg_data;
                CFG_REPEAT_TICKS: repeat_ticks_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (req_take)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
            s1_levels_reg <= req.pressed_levels;
    end

    bcad_step u_step (
        .cur_state    (state_reg),
        .levels       (s1_levels_reg),
        .hold_ticks   (hold_ticks_reg),
        .repeat_ticks (repeat_ticks_reg),
        .next_state   (state_next),
        .event_key    (event_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode        <= MODE_IDLE;
            state_reg.prev_levels <= '0;
            state_reg.countdown   <= '0;
            state_reg.latched_key <= KEY_NONE;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_key_reg <= event_next;
    end

    assign idle_step     = advance && (state_reg.mode == MODE_IDLE);
    assign alt_hold_step = advance && (state_reg.mode == MODE_HELD) &&
                           (state_reg.latched_key == KEY_ALT) &&
                           ((state_reg.prev_levels & ~s1_levels_reg) == '0);
    assign wait_step     = advance && (state_reg.mode == MODE_WAITING);
    assign s1_stalled    = s1_valid_reg && !advance;
    assign out_none      = out_valid_reg && (out_key_reg == KEY_NONE);
    assign step_none     = (event_next == KEY_NONE);

    `BCAD_ASSERT_NEXT(a_idle_no_event, idle_step, out_none, "event emitted from idle")
    `BCAD_ASSERT_NEXT(a_alt_no_repeat, alt_hold_step, out_none, "alt key repeated")
    `BCAD_ASSERT_NEXT(a_stage_holds, s1_stalled, s1_valid_reg, "input stage lost a request")
    `BCAD_ASSERT_NOW(a_waiting_no_event_key, wait_step, step_none, "event emitted while waiting")

endmodule

### hdl/bcad_step.sv
module bcad_step (
    input  bcad_pkg::state_t  cur_state,
    input  bcad_pkg::levels_t levels,
    input  bcad_pkg::ticks_t  hold_ticks,
    input  bcad_pkg::ticks_t  repeat_ticks,
    output bcad_pkg::state_t  next_state,
    output bcad_pkg::key_t    event_key
);
    import bcad_pkg::*;

    levels_t pressed;
    levels_t released;
    levels_t first_released;
    key_t    release_key;
    key_t    level_key;
    ticks_t  count_dec;
    logic    count_done;
    mode_t   mode_next;

    assign pressed        = levels & ~cur_state.prev_levels;
    assign released       = cur_state.prev_levels & ~levels;
    // Isolate the lowest released button: A wins over B over X over Y
    assign first_released = released & (~released + 4'd1);
    assign release_key    = key_of_mask(levels | first_released);
    assign level_key      = key_of_mask(levels);
    assign count_dec      = cur_state.countdown - 16'd1;
    assign count_done     = (count_dec == '0);

    always_comb
    begin
        mode_next = cur_state.mode;
        unique case (cur_state.mode)
            MODE_IDLE:
            begin
                if (|pressed)
                    mode_next = MODE_PRESSED;
            end
            MODE_PRESSED:
            begin
                if (|released)
                    mode_next = key_is_chord(release_key) ? MODE_WAITING : MODE_IDLE;
                else if (count_done)
                    mode_next = MODE_HELD;
            end
            MODE_HELD:
            begin
                if (|released)
                    mode_next = MODE_IDLE;
            end
            MODE_WAITING:
            begin
                // only B, X and Y gate the return to idle
                if (levels[3:1] == 3'b000)
                    mode_next = MODE_IDLE;
            end
            default:
                mode_next = MODE_IDLE;
        endcase
    end

    always_comb
    begin
        event_key              = KEY_NONE;
        next_state.mode        = mode_next;
        next_state.prev_levels = levels;
        next_state.countdown   = cur_state.countdown;
        next_state.latched_key = cur_state.latched_key;
        unique case (cur_state.mode)
            MODE_IDLE:
            begin
                if (|pressed)
                    next_state.countdown = hold_ticks;
            end
            MODE_PRESSED:
            begin
                if (|released)
                begin
                    event_key = release_key;
                end
                else
                begin
                    next_state.countdown = count_dec;
                    if (count_done)
                    begin
                        next_state.latched_key = level_key;
                        event_key              = level_key;
                        next_state.countdown   = repeat_ticks;
                    end
                end
            end
            MODE_HELD:
            begin
                if (|released)
                begin
                    event_key = cur_state.latched_key;
                end
                else if (cur_state.latched_key != KEY_ALT)
                begin
                    next_state.countdown = count_dec;
                    if (count_done)
                    begin
                        event_key            = cur_state.latched_key;
                        next_state.countdown = repeat_ticks;
                    end
                end
            end
            MODE_WAITING:
            begin
                // drop edges
            end
            default:
            begin
            end
        endcase
    end

endmodule
